FILE: hdl/b64d_pkg.sv
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;  // '='
  localparam int         SEQ_BYTES = 5;      // held pair plus one full group

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } char_class_t;

  // One queued job for the back end: bytes to send, oldest in slot 0.
  // A count of zero with last set stands for the empty end marker.
  typedef struct packed {
    logic [SEQ_BYTES-1:0][7:0] byte_seq;
    logic [2:0]                count;
    logic                      last;
  } b64d_job_t;

  // Map a character to its 6-bit value; '=' decodes as zero.
  function automatic char_class_t char_value(input logic [7:0] c);
    char_class_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else if (c == PAD_CHAR) begin
      r.value = 6'd0;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/b64d_if.sv
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_message;

  modport source (output valid, char_code, end_of_message, input ready);
  modport sink   (input valid, char_code, end_of_message, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_of_message;

  modport source (output valid, data_byte, byte_valid, last_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, last_of_message, output ready);
endinterface

FILE: hdl/b64d_front.sv
module b64d_front
  import b64d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  b64d_char_if.sink     char_in,
  input  logic          queue_full,
  output logic          push,
  output b64d_job_t     push_job
);

  logic [23:0]    acc;
  logic [1:0]     group;
  logic [1:0]     pads;
  logic [1:0]     recent;
  logic [1:0]     held_count;
  logic [1:0][7:0] held;

  char_class_t    cv;
  logic           accept;
  logic           is_pad;
  logic [23:0]    acc_next;
  logic [1:0]     group_next;
  logic [1:0]     pads_next;
  logic [1:0]     recent_next;
  logic           group_done;
  logic [SEQ_BYTES-1:0][7:0] seq;
  logic [2:0]     n;
  logic [2:0]     drops;

  assign char_in.ready = !queue_full;
  assign accept = char_in.valid && char_in.ready;
  assign cv     = char_value(char_in.char_code);
  assign is_pad = (char_in.char_code == PAD_CHAR);

  always_comb begin
    acc_next    = acc;
    group_next  = group;
    pads_next   = pads;
    recent_next = recent;
    if (cv.valid) begin
      acc_next    = {acc[17:0], cv.value};
      group_next  = group + 2'd1;
      pads_next   = {pads[0], is_pad};
      recent_next = (recent == 2'd2) ? recent : recent + 2'd1;
    end
  end

  assign group_done = cv.valid && (group_next == 2'd0);

  // Line up held bytes then the new group, oldest first.
  always_comb begin
    seq = '0;
    case (held_count)
      2'd2: begin
        seq[0] = held[0];
        seq[1] = held[1];
        seq[2] = acc_next[23:16];
        seq[3] = acc_next[15:8];
        seq[4] = acc_next[7:0];
      end
      2'd1: begin
        seq[0] = held[0];
        seq[1] = acc_next[23:16];
        seq[2] = acc_next[15:8];
        seq[3] = acc_next[7:0];
      end
      default: begin
        seq[0] = acc_next[23:16];
        seq[1] = acc_next[15:8];
        seq[2] = acc_next[7:0];
      end
    endcase
    n = {1'b0, held_count} + (group_done ? 3'd3 : 3'd0);
    drops = {2'b00, (recent_next != 2'd0) && pads_next[0]}
          + {2'b00, (recent_next == 2'd2) && pads_next[1]};
    if (drops > n) begin
      drops = n;
    end
  end

  always_comb begin
    push_job.byte_seq = seq;
    push_job.last     = char_in.end_of_message;
    push_job.count    = char_in.end_of_message ? (n - drops) : (n - 3'd2);
    push              = accept && (char_in.end_of_message || (n > 3'd2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      group      <= '0;
      pads       <= '0;
      recent     <= '0;
      held_count <= '0;
    end else if (accept) begin
      if (char_in.end_of_message) begin
        acc        <= '0;
        group      <= '0;
        pads       <= '0;
        recent     <= '0;
        held_count <= '0;
      end else begin
        acc    <= acc_next;
        group  <= group_next;
        pads   <= pads_next;
        recent <= recent_next;
        if (group_done) begin
          held_count <= 2'd2;
        end
      end
    end
  end

  // Newest two bytes of a finished group are held back.
  always_ff @(posedge clk) begin
    if (accept && !char_in.end_of_message && group_done) begin
      held[0] <= acc_next[15:8];
      held[1] <= acc_next[7:0];
    end
  end

  property p_push_only_on_accept;
    @(posedge clk) disable iff (rst) push |-> !queue_full;
  endproperty
  a_push_only_on_accept: assert property (p_push_only_on_accept)
    else $error("front pushed into full queue");

endmodule

FILE: hdl/b64d_queue.sv
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  b64d_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output b64d_job_t head_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  b64d_job_t          slots [DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    fill;

  assign full      = (fill == CntW'(DEPTH));
  assign not_empty = (fill != '0);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  property p_fill_bound;
    @(posedge clk) disable iff (rst) fill <= CntW'(DEPTH);
  endproperty
  a_fill_bound: assert property (p_fill_bound)
    else $error("queue fill out of range");

endmodule

FILE: hdl/b64d_back.sv
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       not_empty,
  input  b64d_job_t  head_job,
  output logic       pop,
  b64d_byte_if.source byte_out
);

  logic [2:0] idx;
  logic       load;
  logic       final_slot;

  assign load       = not_empty && (!byte_out.valid || byte_out.ready);
  assign final_slot = (head_job.count == 3'd0) || (idx == head_job.count - 3'd1);
  assign pop        = load && final_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      byte_out.valid <= 1'b0;
    end else begin
      if (load) begin
        byte_out.valid <= 1'b1;
        idx            <= final_slot ? 3'd0 : idx + 3'd1;
      end else if (byte_out.ready) begin
        byte_out.valid <= 1'b0;
      end
    end
  end

  // Hold the word while stalled; advance one slot per send.
  always_ff @(posedge clk) begin
    if (load) begin
      if (head_job.count == 3'd0) begin
        byte_out.data_byte       <= 8'd0;
        byte_out.byte_valid      <= 1'b0;
        byte_out.last_of_message <= 1'b1;
      end else begin
        byte_out.data_byte       <= head_job.byte_seq[idx];
        byte_out.byte_valid      <= 1'b1;
        byte_out.last_of_message <= head_job.last && final_slot;
      end
    end
  end

  property p_marker_is_last;
    @(posedge clk) disable iff (rst)
      (byte_out.valid && !byte_out.byte_valid) |-> byte_out.last_of_message;
  endproperty
  a_marker_is_last: assert property (p_marker_is_last)
    else $error("empty marker without last flag");

  property p_marker_zero;
    @(posedge clk) disable iff (rst)
      (byte_out.valid && !byte_out.byte_valid) |-> (byte_out.data_byte == 8'd0);
  endproperty
  a_marker_zero: assert property (p_marker_zero)
    else $error("empty marker carries data");

  property p_idx_restart;
    @(posedge clk) disable iff (rst) pop |=> (idx == 3'd0);
  endproperty
  a_idx_restart: assert property (p_idx_restart)
    else $error("slot index not restarted after pop");

endmodule

FILE: hdl/base64_stream_decoder_unit.sv
// Base64 stream decoder. Feed one character word per cycle on char_in; mark
// the final character with end_of_message. Characters outside A-Z, a-z, 0-9,
// '+' and '/' are skipped, '=' decodes as zero. Decoded bytes leave on
// byte_out one word per cycle while byte_out is ready; the last word of each
// message has last_of_message set, and a message that leaves no bytes yields
// a single word with byte_valid low. A character is taken every cycle while
// the job queue has room: the front end classifies it combinationally and
// queues a job when a group completes or the message ends, and the back end
// sends one byte per cycle from the queue head while byte_out is ready. Four
// characters make three bytes, so steady input never waits on the back end;
// the end of a message can queue up to five bytes, and QUEUE_DEPTH jobs of
// slack set how long a burst of ends is absorbed before char_in.ready drops.
// Each byte is registered in a queue slot and then in byte_out.
module base64_stream_decoder_unit
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   char_in,
  b64d_byte_if.source byte_out
);

  logic      push;
  b64d_job_t push_job;
  logic      full;
  logic      pop;
  logic      not_empty;
  b64d_job_t head_job;

  // Front end: classify, accumulate, hold back the tail bytes.
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  // Short job queue decouples the two sides.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  // Back end: serialize each job into byte words.
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head_job  (head_job),
    .pop       (pop),
    .byte_out  (byte_out)
  );

endmodule
